>>> design/gwm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gwm_pkg
// shared widths, action codes, pattern character codes and the case-folding
// compare for the glob wildcard matcher
// ----------------------------------------------------------------------------
package gwm_pkg;

    localparam int PATTERN_MAX_DEF = 63;
    localparam int CFG_W           = 6;
    localparam int IDX_W           = 6;
    localparam int CHAR_W          = 16;
    localparam int ACT_W           = 2;

    localparam logic [ACT_W-1:0] ACT_LOAD = 2'd0;
    localparam logic [ACT_W-1:0] ACT_TEXT = 2'd1;
    localparam logic [ACT_W-1:0] ACT_END  = 2'd2;

    localparam logic [CHAR_W-1:0] CH_STAR    = 16'h002A;
    localparam logic [CHAR_W-1:0] CH_QUERY   = 16'h003F;
    localparam logic [CHAR_W-1:0] CH_DOT     = 16'h002E;
    localparam logic [CHAR_W-1:0] CH_UPPER_A = 16'h0041;
    localparam logic [CHAR_W-1:0] CH_UPPER_Z = 16'h005A;
    localparam logic [CHAR_W-1:0] CASE_GAP   = 16'h0020;

    typedef struct packed {
        logic step;
        logic restart;
    } t_cell_ctrl;

    function automatic logic fold_equal(logic [CHAR_W-1:0] a, logic [CHAR_W-1:0] b);
        logic ua;
        logic ub;
        ua = (a >= CH_UPPER_A) && (a <= CH_UPPER_Z);
        ub = (b >= CH_UPPER_A) && (b <= CH_UPPER_Z);
        return (a == b) || (ua && (b == a + CASE_GAP)) || (ub && (a == b + CASE_GAP));
    endfunction

endpackage

>>> design/gwm_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gwm_cell
// one pattern position: holds its pattern character and its active bit,
// matches the text character and hands the advance bit to its right neighbor
// ----------------------------------------------------------------------------
module gwm_cell
    import gwm_pkg::*;
#(
    parameter bit P_START = 1'b0
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cell_ctrl        i_ctrl,
    input  logic              i_load,
    input  logic [CHAR_W-1:0] i_code,
    input  logic              i_in_use,
    input  logic              i_cur,
    input  logic              i_adv,
    input  logic              i_next,
    output logic              o_act,
    output logic              o_star,
    output logic              o_adv,
    output logic              o_next_raw
);

    logic [CHAR_W-1:0] r_char;
    logic              r_act;
    logic              live;
    logic              hit;

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_char <= i_code;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act <= P_START;
        end else if (i_ctrl.step) begin
            r_act <= i_next;
        end else if (i_ctrl.restart) begin
            r_act <= P_START;
        end
    end

    always_comb begin
        live = i_cur & i_in_use;
        if (r_char == CH_QUERY) begin
            hit = (i_code != CH_DOT);
        end else begin
            hit = fold_equal(r_char, i_code);
        end
    end

    assign o_act      = r_act;
    assign o_star     = (r_char == CH_STAR);
    assign o_adv      = live & ~o_star & hit;
    assign o_next_raw = (live & o_star) | i_adv;

endmodule

>>> design/gwm_closure.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gwm_closure
// star closure of a position set: trims it to the pattern length and lets
// every active star reach the next position, as a log-depth prefix network
// ----------------------------------------------------------------------------
module gwm_closure
    import gwm_pkg::*;
#(
    parameter int NPOS = PATTERN_MAX_DEF + 1
) (
    input  logic [NPOS-1:0]         i_set,
    input  logic [NPOS-2:0]         i_prop,
    input  logic [$clog2(NPOS)-1:0] i_len,
    output logic [NPOS-1:0]         o_set
);

    localparam int LVL = $clog2(NPOS);

    logic [NPOS-1:0] c_lvl [LVL+1];
    logic [NPOS-1:0] p_lvl [LVL+1];

    always_comb begin
        for (int j = 0; j < NPOS; j++) begin
            c_lvl[0][j] = i_set[j] & (j <= int'(i_len));
            p_lvl[0][j] = (j >= 1) ? i_prop[(j >= 1) ? j-1 : 0] : 1'b0;
        end
        for (int k = 0; k < LVL; k++) begin
            for (int j = 0; j < NPOS; j++) begin
                if (j >= (1 << k)) begin
                    c_lvl[k+1][j] = c_lvl[k][j] | (c_lvl[k][j-(1<<k)] & p_lvl[k][j]);
                    p_lvl[k+1][j] = p_lvl[k][j] & p_lvl[k][j-(1<<k)];
                end else begin
                    c_lvl[k+1][j] = c_lvl[k][j];
                    p_lvl[k+1][j] = 1'b0;
                end
            end
        end
    end

    assign o_set = c_lvl[LVL];

endmodule

>>> design/glob_wildcard_matcher_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glob_wildcard_matcher_top
// case-insensitive glob match of a streamed text against a loaded pattern,
// one cell per pattern position holding an nfa bit
//
//   channel | direction | handshake                  | word
//   --------+-----------+----------------------------+------------------------------
//   input   | in        | i_valid / o_ready          | i_action, i_pattern_index,
//           |           |                            | i_char_code
//   result  | out       | o_valid / i_ready          | o_matched
//   config  | in        | i_cfg_valid / o_cfg_ready  | i_cfg_data (pattern length)
//
// one word per cycle while o_ready is high; the set update is the cell row plus two closure networks
// a result is registered into the output slot, or into the skid slot while the output is stalled
// two result slots: o_ready drops only while both hold a result
// synchronous active-low reset, no clearing pass, config always ready
// ----------------------------------------------------------------------------
module glob_wildcard_matcher_top
    import gwm_pkg::*;
#(
    parameter int PATTERN_MAX = PATTERN_MAX_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [ACT_W-1:0]  i_action,
    input  logic [IDX_W-1:0]  i_pattern_index,
    input  logic [CHAR_W-1:0] i_char_code,
    output logic              o_valid,
    input  logic              i_ready,
    output logic              o_matched,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [CFG_W-1:0]  i_cfg_data
);

    localparam int NPOS  = PATTERN_MAX + 1;
    localparam int POS_W = $clog2(NPOS);

    logic [CFG_W-1:0] r_len_cfg;
    logic             r_act_end;
    logic             r_out_valid;
    logic             r_out;
    logic             r_skid_valid;
    logic             r_skid;

    logic             accept;
    logic             end_acc;
    t_cell_ctrl       ctrl;
    logic [POS_W-1:0] len;
    logic [NPOS-1:0]  raw_set;
    logic [NPOS-1:0]  cur_set;
    logic [NPOS-1:0]  next_raw;
    logic [NPOS-1:0]  next_set;
    logic [NPOS-2:0]  star;
    logic [NPOS-2:0]  in_use;
    logic [NPOS-2:0]  prop;
    logic [NPOS-2:0]  adv;
    logic             result;

    assign accept       = i_valid & o_ready;
    assign ctrl.step    = accept & (i_action == ACT_TEXT);
    assign ctrl.restart = accept & (i_action == ACT_END);
    assign end_acc      = ctrl.restart;

    assign len = (r_len_cfg > CFG_W'(PATTERN_MAX)) ? POS_W'(PATTERN_MAX) : POS_W'(r_len_cfg);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len_cfg <= '0;
        end else if (i_cfg_valid) begin
            r_len_cfg <= i_cfg_data;
        end
    end

    for (genvar i = 0; i < PATTERN_MAX; i++) begin : g_cell
        assign in_use[i] = (i < int'(len));
        assign prop[i]   = star[i] & in_use[i];

        gwm_cell #(
            .P_START (i == 0)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctrl     (ctrl),
            .i_load     (accept && (i_action == ACT_LOAD)
                         && (i_pattern_index == IDX_W'(i))),
            .i_code     (i_char_code),
            .i_in_use   (in_use[i]),
            .i_cur      (cur_set[i]),
            .i_adv      ((i == 0) ? 1'b0 : adv[(i == 0) ? 0 : i-1]),
            .i_next     (next_set[i]),
            .o_act      (raw_set[i]),
            .o_star     (star[i]),
            .o_adv      (adv[i]),
            .o_next_raw (next_raw[i])
        );
    end

    assign raw_set[PATTERN_MAX]  = r_act_end;
    assign next_raw[PATTERN_MAX] = adv[PATTERN_MAX-1];

    gwm_closure #(.NPOS(NPOS)) u_close_cur (
        .i_set  (raw_set),
        .i_prop (prop),
        .i_len  (len),
        .o_set  (cur_set)
    );

    gwm_closure #(.NPOS(NPOS)) u_close_next (
        .i_set  (next_raw),
        .i_prop (prop),
        .i_len  (len),
        .o_set  (next_set)
    );

    assign result = cur_set[len];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act_end <= 1'b0;
        end else if (ctrl.step) begin
            r_act_end <= next_set[PATTERN_MAX];
        end else if (ctrl.restart) begin
            r_act_end <= 1'b0;
        end
    end

    // two-slot result buffer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || i_ready) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_out        <= r_skid;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= end_acc;
                r_out       <= result;
            end
        end else if (end_acc) begin
            r_skid_valid <= 1'b1;
            r_skid       <= result;
        end
    end

    assign o_ready     = ~r_skid_valid;
    assign o_valid     = r_out_valid;
    assign o_matched   = r_out;
    assign o_cfg_ready = 1'b1;

endmodule

>>> design/gwm_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gwm_checker
// port-level checks on the glob wildcard matcher, bound to the top level
// ----------------------------------------------------------------------------
module gwm_checker
    import gwm_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_valid,
    input logic              o_ready,
    input logic [ACT_W-1:0]  i_action,
    input logic              o_valid,
    input logic              i_ready,
    input logic              o_matched
);

    // held result word stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_matched))
        else $error("result word changed while stalled");

    // a new result follows an accepted end-of-text word
    a_out_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(i_valid && o_ready && (i_action == ACT_END)))
        else $error("result without end of text");

    // loads and text words give no result
    a_no_extra: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid && !(i_valid && o_ready && (i_action == ACT_END)) |=> !o_valid)
        else $error("result from a word that gives none");

    // input stalls only while a result is pending
    a_ready_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(o_ready) |-> o_valid)
        else $error("input stalled without a pending result");

endmodule

bind glob_wildcard_matcher_top gwm_checker u_gwm_checker (.*);

>>> verif/tb_glob_wildcard_matcher_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_glob_wildcard_matcher_top
// self-checking bench for the glob wildcard matcher: loads patterns, streams
// texts built to follow them (plus broken and random ones), predicts every
// end-of-text match bit with an nfa model kept here and checks the results in
// order, with random idle bursts on both channels and a long result stall
// ----------------------------------------------------------------------------
module tb_glob_wildcard_matcher_top;
    import gwm_pkg::*;

    localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;
    localparam logic [IDX_W-1:0] IDX_OUTSIDE = 6'd63;
    localparam int HOLD_CYCLES = 80;

    typedef struct packed {
        logic [ACT_W-1:0]  act;
        logic [IDX_W-1:0]  idx;
        logic [CHAR_W-1:0] ch;
    } t_gwm_word;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_valid = 1'b0;
    logic              o_ready;
    logic [ACT_W-1:0]  i_action = '0;
    logic [IDX_W-1:0]  i_pattern_index = '0;
    logic [CHAR_W-1:0] i_char_code = '0;
    logic              o_valid;
    logic              i_ready = 1'b0;
    logic              o_matched;
    logic              i_cfg_valid = 1'b0;
    logic              o_cfg_ready;
    logic [CFG_W-1:0]  i_cfg_data = '0;

    glob_wildcard_matcher_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_action        (i_action),
        .i_pattern_index (i_pattern_index),
        .i_char_code     (i_char_code),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_matched       (o_matched),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data)
    );

    t_gwm_word         word_q [$];
    logic              expected_matches [$];
    int                words_in_flight = 0;
    int                fed_count = 0;
    int                err_count = 0;
    bit                quiet = 1'b0;
    bit                in_taken = 1'b0;
    int                hold_requests = 0;

    // model state
    logic [CHAR_W-1:0] model_pattern [PATTERN_MAX_DEF];
    logic [63:0]       model_active = 64'd1;
    int unsigned       model_length = 0;

    // stimulus side copy of the pattern store
    logic [CHAR_W-1:0] pattern_copy [PATTERN_MAX_DEF];

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string msg);
        err_count++;
        $display("mismatch at %0t: %s", $realtime, msg);
    endtask

    function automatic logic [CHAR_W-1:0] to_lower(logic [CHAR_W-1:0] c);
        return (c >= CH_UPPER_A && c <= CH_UPPER_Z) ? c + CASE_GAP : c;
    endfunction

    function automatic logic [63:0] spread_stars(logic [63:0] s, int unsigned n);
        logic [63:0] keep;
        keep = (n >= 63) ? '1 : ((64'd1 << (n + 1)) - 64'd1);
        s &= keep;
        for (int k = 0; k < n; k++)
            if (s[k] && model_pattern[k] == CH_STAR) s[k + 1] = 1'b1;
        return s;
    endfunction

    task automatic advance_nfa(input t_gwm_word w);
        logic [63:0] cur;
        logic [63:0] nxt;
        int unsigned n;
        n = (model_length > PATTERN_MAX_DEF) ? PATTERN_MAX_DEF : model_length;
        case (w.act)
            ACT_LOAD: begin
                if (w.idx < PATTERN_MAX_DEF) model_pattern[w.idx] = w.ch;
            end
            ACT_TEXT: begin
                cur = spread_stars(model_active, n);
                nxt = '0;
                for (int k = 0; k < n; k++) begin
                    if (cur[k]) begin
                        if (model_pattern[k] == CH_STAR) nxt[k] = 1'b1;
                        else if (model_pattern[k] == CH_QUERY) nxt[k + 1] = (w.ch != CH_DOT);
                        else if (to_lower(model_pattern[k]) == to_lower(w.ch))
                            nxt[k + 1] = 1'b1;
                    end
                end
                model_active = spread_stars(nxt, n);
            end
            ACT_END: begin
                cur = spread_stars(model_active, n);
                expected_matches.insert(expected_matches.size(), cur[n]);
                model_active = 64'd1;
            end
            default: ;
        endcase
    endtask

    // monitor: input acceptance feeds the model, results are checked in order
    always @(posedge i_clk) begin
        in_taken = 1'b0;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) model_length = i_cfg_data;
            if (i_valid && o_ready) begin
                in_taken = 1'b1;
                words_in_flight--;
                advance_nfa('{i_action, i_pattern_index, i_char_code});
            end
            if (o_valid && i_ready) begin
                if (expected_matches.size() == 0)
                    report_mismatch($sformatf("matched=%0b with nothing pending", o_matched));
                else if (o_matched !== expected_matches[0])
                    report_mismatch($sformatf("matched=%0b, expected %0b",
                                              o_matched, expected_matches[0]));
                if (expected_matches.size() != 0) void'(expected_matches.pop_front());
            end
        end
    end

    // driver: one word per handshake from the pending queue
    int send_gap = 0;
    always @(negedge i_clk) begin
        t_gwm_word w;
        if (i_rst_n) begin
            if (i_valid && !in_taken) begin
            end else if (send_gap > 0) begin
                send_gap--;
                i_valid <= 1'b0;
            end else if (!quiet && $urandom_range(0, 9) == 0) begin
                send_gap = $urandom_range(1, 13) - 1;
                i_valid <= 1'b0;
            end else if (word_q.size() != 0) begin
                w = word_q.pop_front();
                i_valid <= 1'b1;
                i_action <= w.act;
                i_pattern_index <= w.idx;
                i_char_code <= w.ch;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // result side ready, with idle bursts and one long hold
    int recv_gap = 0;
    int hold_left = 0;
    int holds_served = 0;
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (hold_requests != holds_served) begin
                holds_served = hold_requests;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_ready <= 1'b0;
            end else if (recv_gap > 0) begin
                recv_gap--;
                i_ready <= 1'b0;
            end else if (!quiet && $urandom_range(0, 7) == 0) begin
                recv_gap = $urandom_range(1, 13) - 1;
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    task automatic queue_word(logic [ACT_W-1:0] act, logic [IDX_W-1:0] idx,
                              logic [CHAR_W-1:0] ch);
        word_q.insert(word_q.size(), '{act, idx, ch});
        words_in_flight++;
        if (act != ACT_UNUSED && !(act == ACT_LOAD && idx >= PATTERN_MAX_DEF)) fed_count++;
    endtask

    task automatic queue_text(logic [CHAR_W-1:0] ch);
        queue_word(ACT_TEXT, IDX_W'($urandom_range(0, 63)), ch);
    endtask

    task automatic queue_end();
        queue_word(ACT_END, IDX_W'($urandom_range(0, 63)), CHAR_W'($urandom_range(0, 65535)));
    endtask

    task automatic set_entry(int idx, logic [CHAR_W-1:0] ch);
        pattern_copy[idx] = ch;
        queue_word(ACT_LOAD, IDX_W'(idx), ch);
    endtask

    function automatic logic [CHAR_W-1:0] pick_char();
        case ($urandom_range(0, 15))
            0:       return 16'h0061;
            1:       return 16'h0062;
            2:       return 16'h007A;
            3:       return 16'h0041;
            4:       return 16'h0042;
            5:       return 16'h005A;
            6:       return CH_DOT;
            7:       return 16'h0040;
            8:       return 16'h0060;
            9:       return 16'h005B;
            10:      return 16'h007B;
            11:      return 16'h00E9;
            12:      return 16'h00C9;
            13:      return CH_QUERY;
            14:      return CH_STAR;
            default: return CHAR_W'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic logic [CHAR_W-1:0] pick_pattern_char();
        case ($urandom_range(0, 9))
            0, 1:    return CH_STAR;
            2, 3:    return CH_QUERY;
            default: return pick_char();
        endcase
    endfunction

    // text that mostly follows the current pattern, sometimes broken or random
    task automatic emit_text(int unsigned n);
        logic [CHAR_W-1:0] c;
        int reps;
        if ($urandom_range(0, 7) == 0) begin
            reps = $urandom_range(0, 6);
            repeat (reps) queue_text(pick_char());
        end else begin
            for (int k = 0; k < n; k++) begin
                c = pattern_copy[k];
                if ($urandom_range(0, 63) == 0)
                    set_entry($urandom_range(0, PATTERN_MAX_DEF - 1), pick_pattern_char());
                if ($urandom_range(0, 79) == 0)
                    queue_word(ACT_UNUSED, IDX_W'($urandom_range(0, 63)), pick_char());
                if ($urandom_range(0, 31) == 0) begin
                    queue_text(pick_char());
                end else if (c == CH_STAR) begin
                    reps = $urandom_range(0, 3);
                    repeat (reps) queue_text(pick_char());
                end else if (c == CH_QUERY) begin
                    queue_text(pick_char());
                end else if ($urandom_range(0, 1) == 0 && c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
                    queue_text(c + CASE_GAP);
                end else if ($urandom_range(0, 1) == 0 && c >= 16'h0061 && c <= 16'h007A) begin
                    queue_text(c - CASE_GAP);
                end else begin
                    queue_text(c);
                end
            end
            if ($urandom_range(0, 5) == 0) queue_text(pick_char());
        end
        queue_end();
    endtask

    task automatic wait_drained();
        while (words_in_flight != 0 || expected_matches.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_length(logic [CFG_W-1:0] len);
        wait_drained();
        i_cfg_data <= len;
        i_cfg_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        #10_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        int unsigned len;
        int phase;
        int budget;
        for (int k = 0; k < PATTERN_MAX_DEF; k++) model_pattern[k] = '0;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // fill the whole store so no unwritten entry is ever read
        for (int k = 0; k < PATTERN_MAX_DEF; k++) set_entry(k, pick_pattern_char());
        write_length(0);

        // empty pattern, ignored words
        queue_end();
        queue_text(16'h0078);
        queue_end();
        queue_word(ACT_UNUSED, 6'd5, 16'h0061);
        queue_word(ACT_LOAD, IDX_OUTSIDE, 16'hFFFF);
        queue_end();

        // pattern A ? * e-acute z
        set_entry(0, 16'h0041);
        set_entry(1, CH_QUERY);
        set_entry(2, CH_STAR);
        set_entry(3, 16'h00E9);
        set_entry(4, 16'h007A);
        write_length(5);
        queue_text(16'h0061); queue_text(16'h0062); queue_text(16'h00E9);
        queue_text(16'h005A); queue_end();
        queue_text(16'h0041); queue_text(CH_DOT); queue_text(16'h00E9);
        queue_text(16'h007A); queue_end();
        queue_text(16'h0061); queue_text(16'h0071); queue_text(16'hFFFF);
        queue_text(16'h0000); queue_text(16'h00E9); queue_text(16'h005A); queue_end();
        queue_text(16'h0061); queue_text(16'h0071); queue_text(16'h00C9);
        queue_text(16'h007A); queue_end();

        // long result stall while words keep coming
        wait_drained();
        hold_requests++;
        repeat (12) emit_text(5);

        phase = 0;
        while (fed_count < 700) begin
            if (phase == 0) len = 63;
            else if (phase == 1) len = 1;
            else begin
                case ($urandom_range(0, 19))
                    0:       len = 0;
                    1:       len = 63;
                    2, 3, 4: len = $urandom_range(9, 20);
                    default: len = $urandom_range(1, 8);
                endcase
            end
            for (int k = 0; k < len; k++) set_entry(k, pick_pattern_char());
            if ($urandom_range(0, 3) == 0)
                queue_word(ACT_LOAD, IDX_OUTSIDE, CHAR_W'($urandom_range(0, 65535)));
            write_length(CFG_W'(len));
            if (fed_count > 600) quiet = 1'b1;
            budget = fed_count + 40;
            while (fed_count < budget) emit_text(len);
            phase++;
        end

        wait_drained();
        repeat (8) @(negedge i_clk);
        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
